### rtl/gcpg_pkg.sv
// shared types and constants of the gapped circle point generator
`default_nettype none

package gcpg_pkg;

    localparam int RADIUS_W = 7;
    localparam int COORD_W  = 8;
    localparam int GAP_W    = 4;
    localparam int MASK_W   = 4;
    localparam int SQ_W     = 2 * RADIUS_W;
    localparam int SUM_W    = SQ_W + 1;

    localparam int MAX_POINTS = 57;
    localparam int COUNT_W    = $clog2(MAX_POINTS);

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_TOP    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_BOTTOM = 1'b1;

    localparam logic [COORD_W-1:0] CLIP_TOP_RESET    = 8'd23;
    localparam logic [COORD_W-1:0] CLIP_BOTTOM_RESET = 8'd136;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_R,
        ST_SQ_X,
        ST_FIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] operand;
        logic [SQ_W-1:0]     base;
        logic [SQ_W-1:0]     limit;
    } sq_req_t;

    typedef struct packed {
        logic [SQ_W-1:0] square;
        logic            over;
    } sq_rsp_t;

endpackage

`default_nettype wire

### rtl/gapped_circle_point_generator.sv
// top level: sequencer, configuration registers and result register
//
// s_ channel takes one circle request (radius, center_x, center_y, gap_step);
// m_ channel returns one result per walked x step: offsets, clip group mask
// and last_point on the final result of the request. A radius at or above
// RADIUS_LIMIT produces no result; a gap of zero walks in steps of one.
// clip_top and clip_bottom are written through cfg_wr_en / cfg_addr /
// cfg_wdata; the user must write them only while the block is idle, as the
// block itself does not enforce it. One shared squarer does the squaring
// and the compare against the squared radius. A request is loaded in
// ST_IDLE and squares the radius in ST_SQ_R; per result it squares x in
// ST_SQ_X, tests y in ST_FIT (again after each y decrement) and loads the
// result register in ST_EMIT. s_ready is high only between requests.
// Results sit in an output register; while the receiver stalls the walk
// halts at the next result, and a new request is still taken once the walk
// is done even if the final result waits. Reset empties the block and loads
// the clip registers with 23 and 136.
`default_nettype none

module gapped_circle_point_generator #(
    parameter int RADIUS_LIMIT = 80
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_wr_en,
    input  wire logic [gcpg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [gcpg_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [gcpg_pkg::RADIUS_W-1:0]      s_radius,
    input  wire logic [gcpg_pkg::COORD_W-1:0]       s_center_x,
    input  wire logic [gcpg_pkg::COORD_W-1:0]       s_center_y,
    input  wire logic [gcpg_pkg::GAP_W-1:0]         s_gap_step,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [gcpg_pkg::RADIUS_W-1:0]      m_offset_x,
    output logic      [gcpg_pkg::RADIUS_W-1:0]      m_offset_y,
    output logic      [gcpg_pkg::MASK_W-1:0]        m_group_mask,
    output logic                                    m_last_point
);

    localparam logic [gcpg_pkg::RADIUS_W:0] LIMIT = (gcpg_pkg::RADIUS_W + 1)'(RADIUS_LIMIT);
    localparam logic [gcpg_pkg::COUNT_W-1:0] LAST_COUNT =
        gcpg_pkg::COUNT_W'(gcpg_pkg::MAX_POINTS - 1);

    gcpg_pkg::state_t state_reg, state_next;

    logic [gcpg_pkg::COORD_W-1:0]  clip_top_reg, clip_bottom_reg;
    logic [gcpg_pkg::RADIUS_W-1:0] radius_reg, radius_next;
    logic [gcpg_pkg::COORD_W-1:0]  cy_reg, cy_next;
    logic [gcpg_pkg::GAP_W-1:0]    gap_reg, gap_next;
    logic [gcpg_pkg::RADIUS_W-1:0] x_reg, x_next;
    logic [gcpg_pkg::RADIUS_W-1:0] y_reg, y_next;
    logic [gcpg_pkg::SQ_W-1:0]     rr_reg, rr_next;
    logic [gcpg_pkg::SQ_W-1:0]     xx_reg, xx_next;
    logic [gcpg_pkg::COUNT_W-1:0]  n_reg, n_next;

    logic                          m_valid_reg, m_valid_next;
    logic [gcpg_pkg::RADIUS_W-1:0] out_x_reg, out_x_next;
    logic [gcpg_pkg::RADIUS_W-1:0] out_y_reg, out_y_next;
    logic [gcpg_pkg::MASK_W-1:0]   out_mask_reg, out_mask_next;
    logic                          out_last_reg, out_last_next;

    gcpg_pkg::sq_req_t sq_req;
    gcpg_pkg::sq_rsp_t sq_rsp;
    logic [gcpg_pkg::MASK_W-1:0]   mask;
    logic [gcpg_pkg::RADIUS_W:0]   nx;
    logic                          last;
    logic                          slot_free;

    gcpg_square_unit u_square (
        .req (sq_req),
        .rsp (sq_rsp)
    );

    gcpg_clip_mask u_clip (
        .center_y    (cy_reg),
        .offset_x    (x_reg),
        .offset_y    (y_reg),
        .clip_top    (clip_top_reg),
        .clip_bottom (clip_bottom_reg),
        .group_mask  (mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_top_reg    <= gcpg_pkg::CLIP_TOP_RESET;
            clip_bottom_reg <= gcpg_pkg::CLIP_BOTTOM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                gcpg_pkg::CFG_CLIP_TOP:    clip_top_reg    <= cfg_wdata;
                gcpg_pkg::CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gcpg_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        radius_reg   <= radius_next;
        cy_reg       <= cy_next;
        gap_reg      <= gap_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        rr_reg       <= rr_next;
        xx_reg       <= xx_next;
        n_reg        <= n_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_mask_reg <= out_mask_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        radius_next   = radius_reg;
        cy_next       = cy_reg;
        gap_next      = gap_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        rr_next       = rr_reg;
        xx_next       = xx_reg;
        n_next        = n_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_mask_next = out_mask_reg;
        out_last_next = out_last_reg;

        slot_free     = !m_valid_reg || m_ready;
        m_valid_next  = m_valid_reg && !m_ready;
        s_ready       = (state_reg == gcpg_pkg::ST_IDLE);

        nx   = {1'b0, x_reg} + (gcpg_pkg::RADIUS_W + 1)'(gap_reg);
        last = (nx > {1'b0, y_reg}) || (n_reg == LAST_COUNT);

        sq_req.base  = xx_reg;
        sq_req.limit = rr_reg;
        unique case (state_reg)
            gcpg_pkg::ST_SQ_R: sq_req.operand = radius_reg;
            gcpg_pkg::ST_SQ_X: sq_req.operand = x_reg;
            default:           sq_req.operand = y_reg;
        endcase

        unique case (state_reg)
            gcpg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    radius_next = s_radius;
                    cy_next     = s_center_y;
                    gap_next    = (s_gap_step == '0) ? gcpg_pkg::GAP_W'(1) : s_gap_step;
                    x_next      = '0;
                    y_next      = s_radius;
                    n_next      = '0;
                    if ({1'b0, s_radius} < LIMIT) begin
                        state_next = gcpg_pkg::ST_SQ_R;
                    end
                end
            end
            gcpg_pkg::ST_SQ_R: begin
                rr_next    = sq_rsp.square;
                state_next = gcpg_pkg::ST_SQ_X;
            end
            gcpg_pkg::ST_SQ_X: begin
                xx_next    = sq_rsp.square;
                state_next = gcpg_pkg::ST_FIT;
            end
            gcpg_pkg::ST_FIT: begin
                if (y_reg != '0 && sq_rsp.over) begin
                    y_next = y_reg - gcpg_pkg::RADIUS_W'(1);
                end else begin
                    state_next = gcpg_pkg::ST_EMIT;
                end
            end
            gcpg_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    out_x_next    = x_reg;
                    out_y_next    = y_reg;
                    out_mask_next = mask;
                    out_last_next = last;
                    if (last) begin
                        state_next = gcpg_pkg::ST_IDLE;
                    end else begin
                        x_next     = nx[gcpg_pkg::RADIUS_W-1:0];
                        n_next     = n_reg + gcpg_pkg::COUNT_W'(1);
                        state_next = gcpg_pkg::ST_SQ_X;
                    end
                end
            end
            default: state_next = gcpg_pkg::ST_IDLE;
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_offset_x   = out_x_reg;
    assign m_offset_y   = out_y_reg;
    assign m_group_mask = out_mask_reg;
    assign m_last_point = out_last_reg;

    // every emitted point lies on or inside the circle
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gcpg_pkg::ST_EMIT |-> !sq_rsp.over)
        else $error("emitted point outside circle");

    // a y test at zero always ends the search
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gcpg_pkg::ST_FIT && y_reg == '0 |=> state_reg == gcpg_pkg::ST_EMIT)
        else $error("y search did not stop at zero");

    // a result is loaded only into a free output slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_offset_x) && $stable(m_last_point))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### rtl/gcpg_square_unit.sv
// shared squarer with add and compare against the squared radius
`default_nettype none

module gcpg_square_unit (
    input  wire gcpg_pkg::sq_req_t req,
    output gcpg_pkg::sq_rsp_t      rsp
);

    logic [gcpg_pkg::SQ_W-1:0]  square;
    logic [gcpg_pkg::SUM_W-1:0] sum;

    always_comb begin
        square     = gcpg_pkg::SQ_W'(req.operand) * gcpg_pkg::SQ_W'(req.operand);
        sum        = {1'b0, req.base} + {1'b0, square};
        rsp.square = square;
        rsp.over   = sum > {1'b0, req.limit};
    end

endmodule

`default_nettype wire

### rtl/gcpg_clip_mask.sv
// vertical clip tests for the four mirrored point groups
`default_nettype none

module gcpg_clip_mask (
    input  wire logic [gcpg_pkg::COORD_W-1:0]  center_y,
    input  wire logic [gcpg_pkg::RADIUS_W-1:0] offset_x,
    input  wire logic [gcpg_pkg::RADIUS_W-1:0] offset_y,
    input  wire logic [gcpg_pkg::COORD_W-1:0]  clip_top,
    input  wire logic [gcpg_pkg::COORD_W-1:0]  clip_bottom,
    output logic      [gcpg_pkg::MASK_W-1:0]   group_mask
);

    localparam int W = gcpg_pkg::COORD_W + 1;

    logic [W-1:0] cy;
    logic [W-1:0] top;
    logic [W-1:0] bot;
    logic [W-1:0] dx;
    logic [W-1:0] dy;

    always_comb begin
        cy  = W'(center_y);
        top = W'(clip_top);
        bot = W'(clip_bottom);
        dx  = W'(offset_x);
        dy  = W'(offset_y);
        // cy - d > top rewritten as cy > top + d so nothing goes negative
        group_mask[0] = (cy + dy) < bot;
        group_mask[1] = cy > (top + dy);
        group_mask[2] = (cy + dx) < bot;
        group_mask[3] = cy > (top + dx);
    end

endmodule

`default_nettype wire

### test/gapped_circle_point_generator_tb.sv
// testbench of the gapped circle point generator: directed and random circles, clip windows
`timescale 1ns / 100ps

module gapped_circle_point_generator_tb;

    localparam int RADIUS_LIMIT   = 80;
    localparam int DRAIN_CYCLES   = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_IDLE       = 14;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [gcpg_pkg::RADIUS_W-1:0] offset_x;
        logic [gcpg_pkg::RADIUS_W-1:0] offset_y;
        logic [gcpg_pkg::MASK_W-1:0]   group_mask;
        logic                          last_point;
    } circle_point_t;

    logic                            aclk         = 1'b0;
    logic                            aresetn      = 1'b0;
    logic                            cfg_wr_en    = 1'b0;
    logic [gcpg_pkg::CFG_ADDR_W-1:0] cfg_addr     = gcpg_pkg::CFG_CLIP_TOP;
    logic [gcpg_pkg::CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                            s_valid      = 1'b0;
    logic                            s_ready;
    logic [gcpg_pkg::RADIUS_W-1:0]   s_radius     = '0;
    logic [gcpg_pkg::COORD_W-1:0]    s_center_x   = '0;
    logic [gcpg_pkg::COORD_W-1:0]    s_center_y   = '0;
    logic [gcpg_pkg::GAP_W-1:0]      s_gap_step   = '0;
    logic                            m_valid;
    logic                            m_ready      = 1'b0;
    logic [gcpg_pkg::RADIUS_W-1:0]   m_offset_x;
    logic [gcpg_pkg::RADIUS_W-1:0]   m_offset_y;
    logic [gcpg_pkg::MASK_W-1:0]     m_group_mask;
    logic                            m_last_point;

    circle_point_t octant_points[$];
    int            clip_top_q    = int'(gcpg_pkg::CLIP_TOP_RESET);
    int            clip_bottom_q = int'(gcpg_pkg::CLIP_BOTTOM_RESET);
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int            ready_hold     = 0;
    bit            steady_flow    = 1'b0;

    gapped_circle_point_generator #(
        .RADIUS_LIMIT(RADIUS_LIMIT)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_radius     (s_radius),
        .s_center_x   (s_center_x),
        .s_center_y   (s_center_y),
        .s_gap_step   (s_gap_step),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_offset_x   (m_offset_x),
        .m_offset_y   (m_offset_y),
        .m_group_mask (m_group_mask),
        .m_last_point (m_last_point)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int idle_draw();
        return steady_flow ? 0 : int'($urandom_range(0, MAX_IDLE));
    endfunction

    function automatic logic [gcpg_pkg::MASK_W-1:0] clip_groups(int cy, int x, int y);
        logic [gcpg_pkg::MASK_W-1:0] groups;
        groups    = '0;
        groups[0] = (cy + y < clip_bottom_q);
        groups[1] = (cy - y > clip_top_q);
        groups[2] = (cy + x < clip_bottom_q);
        groups[3] = (cy - x > clip_top_q);
        return groups;
    endfunction

    // eighth-circle walk; y shrinks until the point sits on or inside the circle
    function automatic void walk_octant(logic [gcpg_pkg::RADIUS_W-1:0] radius,
                                        logic [gcpg_pkg::COORD_W-1:0] center_y,
                                        logic [gcpg_pkg::GAP_W-1:0] gap_step);
        int r;
        int cy;
        int step;
        int x;
        int y;
        int nx;
        int n;
        circle_point_t p;
        r  = int'(radius);
        cy = int'(center_y);
        if (r >= RADIUS_LIMIT) begin
            return;
        end
        step = (gap_step == '0) ? 1 : int'(gap_step);
        x    = 0;
        y    = r;
        n    = 0;
        while (x <= y && n < gcpg_pkg::MAX_POINTS) begin
            while (y > 0 && x * x + y * y > r * r) begin
                y--;
            end
            nx           = x + step;
            p.offset_x   = gcpg_pkg::RADIUS_W'(x);
            p.offset_y   = gcpg_pkg::RADIUS_W'(y);
            p.group_mask = clip_groups(cy, x, y);
            p.last_point = (nx > y) || (n + 1 == gcpg_pkg::MAX_POINTS);
            octant_points.push_back(p);
            n++;
            x = nx;
        end
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0.1f ns: %s", $realtime, msg);
        end
    endfunction

    // valid stays high after a request until the next call decides to idle
    task automatic send_circle(logic [gcpg_pkg::RADIUS_W-1:0] radius,
                               logic [gcpg_pkg::COORD_W-1:0] center_x,
                               logic [gcpg_pkg::COORD_W-1:0] center_y,
                               logic [gcpg_pkg::GAP_W-1:0] gap_step);
        int gap_cycles;
        gap_cycles = idle_draw();
        if (gap_cycles > 0) begin
            s_valid <= 1'b0;
            repeat (gap_cycles) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_radius   <= radius;
        s_center_x <= center_x;
        s_center_y <= center_y;
        s_gap_step <= gap_step;
        do @(posedge aclk); while (!s_ready);
        walk_octant(radius, center_y, gap_step);
    endtask

    task automatic send_random_circle();
        logic [gcpg_pkg::RADIUS_W-1:0] radius;
        if ($urandom_range(0, 9) < 8) begin
            radius = gcpg_pkg::RADIUS_W'($urandom_range(0, RADIUS_LIMIT - 1));
        end else begin
            radius = gcpg_pkg::RADIUS_W'($urandom_range(RADIUS_LIMIT, 127));
        end
        send_circle(radius, gcpg_pkg::COORD_W'($urandom_range(0, 255)),
                    gcpg_pkg::COORD_W'($urandom_range(0, 255)),
                    gcpg_pkg::GAP_W'($urandom_range(0, 15)));
    endtask

    // an oversized radius gives no result, so wait out a possible walk too
    task automatic settle();
        s_valid <= 1'b0;
        while (octant_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_clip_window(logic [gcpg_pkg::CFG_DATA_W-1:0] top,
                                   logic [gcpg_pkg::CFG_DATA_W-1:0] bottom);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= gcpg_pkg::CFG_CLIP_TOP;
        cfg_wdata <= top;
        @(posedge aclk);
        cfg_addr  <= gcpg_pkg::CFG_CLIP_BOTTOM;
        cfg_wdata <= bottom;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        clip_top_q    = int'(top);
        clip_bottom_q = int'(bottom);
    endtask

    task automatic test_directed_shapes();
        steady_flow = 1'b0;
        send_circle(7'd0, 8'd0, 8'd0, 4'd0);
        send_circle(7'd0, 8'd255, 8'd255, 4'd15);
        send_circle(7'd1, 8'd128, 8'd80, 4'd1);
        send_circle(7'd2, 8'd17, 8'd90, 4'd2);
        send_circle(7'd79, 8'd0, 8'd128, 4'd1);
        send_circle(7'd79, 8'd255, 8'd0, 4'd15);
        send_circle(7'd79, 8'd100, 8'd255, 4'd0);
        send_circle(7'd80, 8'd50, 8'd50, 4'd1);
        send_circle(7'd127, 8'd255, 8'd255, 4'd15);
        send_circle(7'd64, 8'd85, 8'd170, 4'd7);
        send_circle(7'd78, 8'd42, 8'd79, 4'd8);
        send_circle(7'd40, 8'd200, 8'd23, 4'd1);
        send_circle(7'd40, 8'd3, 8'd136, 4'd3);
        send_circle(7'd5, 8'd99, 8'd24, 4'd4);
        send_circle(7'd33, 8'd170, 8'd135, 4'd10);
        steady_flow = 1'b1;
        send_circle(7'd85, 8'd1, 8'd2, 4'd5);
        send_circle(7'd12, 8'd254, 8'd1, 4'd12);
        send_circle(7'd63, 8'd127, 8'd127, 4'd1);
        settle();
    endtask

    task automatic test_clip_extremes();
        logic [gcpg_pkg::CFG_DATA_W-1:0] tops[4]    = '{8'd0, 8'd255, 8'd0, 8'd255};
        logic [gcpg_pkg::CFG_DATA_W-1:0] bottoms[4] = '{8'd255, 8'd0, 8'd0, 8'd255};
        for (int i = 0; i < 4; i++) begin
            set_clip_window(tops[i], bottoms[i]);
            steady_flow = (i == 2);
            repeat (10) send_random_circle();
            settle();
        end
    endtask

    task automatic test_random_circles();
        for (int phase = 0; phase < 6; phase++) begin
            set_clip_window(gcpg_pkg::CFG_DATA_W'($urandom_range(0, 255)),
                            gcpg_pkg::CFG_DATA_W'($urandom_range(0, 255)));
            steady_flow = (phase % 3 == 2);
            repeat (50) send_random_circle();
            settle();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_shapes();
        test_clip_extremes();
        test_random_circles();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    always @(posedge aclk) begin : result_check
        circle_point_t got;
        circle_point_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_offset_x, m_offset_y, m_group_mask, m_last_point};
            if (octant_points.size() == 0) begin
                note_failure($sformatf("unexpected point x=%0d y=%0d mask=%b last=%b",
                                       got.offset_x, got.offset_y, got.group_mask,
                                       got.last_point));
            end else begin
                want = octant_points.pop_front();
                if (got !== want) begin
                    note_failure($sformatf(
                        "mismatch: expected x=%0d y=%0d mask=%b last=%b, got x=%0d y=%0d mask=%b last=%b",
                        want.offset_x, want.offset_y, want.group_mask, want.last_point,
                        got.offset_x, got.offset_y, got.group_mask, got.last_point));
                end
            end
            ready_hold = idle_draw();
        end
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

endmodule

### files.f
rtl/gcpg_pkg.sv
rtl/gcpg_square_unit.sv
rtl/gcpg_clip_mask.sv
rtl/gapped_circle_point_generator.sv
test/gapped_circle_point_generator_tb.sv
